@@ design/srcc_pkg.sv @@
// ---------------------------------------------------------------------------
// srcc_pkg
// types and codes shared by the ring credit controller files
// ---------------------------------------------------------------------------
package srcc_pkg;

	// event kinds
	localparam logic [2:0] KIND_OPEN     = 3'd0;
	localparam logic [2:0] KIND_SEND     = 3'd1;
	localparam logic [2:0] KIND_COMPLETE = 3'd2;
	localparam logic [2:0] KIND_RECLAIM  = 3'd3;
	localparam logic [2:0] KIND_POLL     = 3'd4;

	// result status codes
	localparam logic [1:0] STATUS_DONE      = 2'd0;
	localparam logic [1:0] STATUS_TOO_LONG  = 2'd1;
	localparam logic [1:0] STATUS_NO_CREDIT = 2'd2;

	// register indexes (word addresses)
	localparam logic [1:0] REG_RING_SLOTS_LOG2      = 2'd0;
	localparam logic [1:0] REG_MAX_PAYLOAD          = 2'd1;
	localparam logic [1:0] REG_INITIAL_SEND_CREDITS = 2'd2;
	localparam logic [1:0] REG_GRANT_ON_OPEN        = 2'd3;

	localparam int unsigned PADDR_BITS = 4;

	// register reset values
	localparam logic [3:0]  RST_RING_SLOTS_LOG2      = 4'd8;
	localparam logic [15:0] RST_MAX_PAYLOAD          = 16'd1992;
	localparam logic [12:0] RST_INITIAL_SEND_CREDITS = 13'd0;
	localparam logic        RST_GRANT_ON_OPEN        = 1'b1;

	typedef struct packed {
		logic [3:0]  ring_slots_log2;
		logic [15:0] max_payload;
		logic [12:0] initial_send_credits;
		logic        grant_on_open;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] payload_length;
		logic [31:0] peer_credit_slot_a;
		logic [31:0] peer_credit_slot_b;
		logic [31:0] peer_posted_count;
		logic        peer_ready;
	} item_t;

	// result fields of fixed width; the slot index travels beside it
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] counter_value;
		logic        credit_write_valid;
		logic        credit_write_slot;
		logic [31:0] credit_write_value;
		logic        clear_slot_a;
		logic        clear_slot_b;
		logic [30:0] new_packets;
		logic [31:0] credits_now;
	} result_t;

endpackage

@@ design/srcc_cmd_if.sv @@
// ---------------------------------------------------------------------------
// srcc_cmd_if
// event channel into the ring credit controller
// ---------------------------------------------------------------------------
interface srcc_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] payload_length;
	logic [31:0] peer_credit_slot_a;
	logic [31:0] peer_credit_slot_b;
	logic [31:0] peer_posted_count;
	logic        peer_ready;

	modport source (
		output valid, kind, payload_length, peer_credit_slot_a, peer_credit_slot_b,
		       peer_posted_count, peer_ready,
		input  ready
	);
	modport sink (
		input  valid, kind, payload_length, peer_credit_slot_a, peer_credit_slot_b,
		       peer_posted_count, peer_ready,
		output ready
	);
endinterface

@@ design/srcc_rsp_if.sv @@
// ---------------------------------------------------------------------------
// srcc_rsp_if
// result channel out of the ring credit controller
// ---------------------------------------------------------------------------
interface srcc_rsp_if #(
	parameter int unsigned SLOT_INDEX_BITS = 12
);
	logic                       valid;
	logic                       ready;
	logic [1:0]                 status;
	logic [SLOT_INDEX_BITS-1:0] slot_index;
	logic [31:0]                counter_value;
	logic                       credit_write_valid;
	logic                       credit_write_slot;
	logic [31:0]                credit_write_value;
	logic                       clear_slot_a;
	logic                       clear_slot_b;
	logic [30:0]                new_packets;
	logic [31:0]                credits_now;

	modport source (
		output valid, status, slot_index, counter_value, credit_write_valid,
		       credit_write_slot, credit_write_value, clear_slot_a, clear_slot_b,
		       new_packets, credits_now,
		input  ready
	);
	modport sink (
		input  valid, status, slot_index, counter_value, credit_write_valid,
		       credit_write_slot, credit_write_value, clear_slot_a, clear_slot_b,
		       new_packets, credits_now,
		output ready
	);
endinterface

@@ design/srcc_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// srcc_cfg_regs
// apb register bank holding the controller configuration
// ---------------------------------------------------------------------------
module srcc_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [srcc_pkg::PADDR_BITS-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output srcc_pkg::cfg_t                  cfg
);
	import srcc_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ring_slots_log2      <= RST_RING_SLOTS_LOG2;
			cfg_q.max_payload          <= RST_MAX_PAYLOAD;
			cfg_q.initial_send_credits <= RST_INITIAL_SEND_CREDITS;
			cfg_q.grant_on_open        <= RST_GRANT_ON_OPEN;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_RING_SLOTS_LOG2:      cfg_q.ring_slots_log2      <= pwdata[3:0];
				REG_MAX_PAYLOAD:          cfg_q.max_payload          <= pwdata[15:0];
				REG_INITIAL_SEND_CREDITS: cfg_q.initial_send_credits <= pwdata[12:0];
				REG_GRANT_ON_OPEN:        cfg_q.grant_on_open        <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RING_SLOTS_LOG2:      prdata = {28'd0, cfg_q.ring_slots_log2};
			REG_MAX_PAYLOAD:          prdata = {16'd0, cfg_q.max_payload};
			REG_INITIAL_SEND_CREDITS: prdata = {19'd0, cfg_q.initial_send_credits};
			REG_GRANT_ON_OPEN:        prdata = {31'd0, cfg_q.grant_on_open};
			default:                  prdata = 32'd0;
		endcase
	end

endmodule

@@ design/srcc_in_reg.sv @@
// ---------------------------------------------------------------------------
// srcc_in_reg
// input register stage for event beats
// ---------------------------------------------------------------------------
module srcc_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	srcc_cmd_if.sink        cmd,
	input  logic            advance,
	output logic            valid_s1,
	output srcc_pkg::item_t item_s1
);
	import srcc_pkg::*;

	logic take;

	assign cmd.ready = ~valid_s1 | advance;
	assign take      = cmd.valid & cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.kind               <= cmd.kind;
			item_s1.payload_length     <= cmd.payload_length;
			item_s1.peer_credit_slot_a <= cmd.peer_credit_slot_a;
			item_s1.peer_credit_slot_b <= cmd.peer_credit_slot_b;
			item_s1.peer_posted_count  <= cmd.peer_posted_count;
			item_s1.peer_ready         <= cmd.peer_ready;
		end
	end

endmodule

@@ design/srcc_engine.sv @@
// ---------------------------------------------------------------------------
// srcc_engine
// endpoint state and the per-event update logic
// ---------------------------------------------------------------------------
module srcc_engine #(
	parameter int unsigned SLOT_INDEX_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  srcc_pkg::item_t             item,
	input  srcc_pkg::cfg_t              cfg,
	output srcc_pkg::result_t           result,
	output logic [SLOT_INDEX_BITS-1:0]  slot_index
);
	import srcc_pkg::*;

	localparam logic [4:0] MAX_LOG2 = 5'(SLOT_INDEX_BITS);

	logic [31:0]                send_credit_q, send_credit_d;
	logic [31:0]                owed_q, owed_d;
	logic                       ret_sel_q, ret_sel_d;
	logic [SLOT_INDEX_BITS-1:0] tx_slot_q, tx_slot_d;
	logic [31:0]                tx_posted_q, tx_posted_d;
	logic [SLOT_INDEX_BITS-1:0] rx_slot_q, rx_slot_d;
	logic [31:0]                rx_processed_q, rx_processed_d;

	logic [4:0]                 log2_sat;
	logic [31:0]                slots;
	logic [31:0]                half;
	logic [SLOT_INDEX_BITS-1:0] mask;
	logic [SLOT_INDEX_BITS-1:0] tx_cur, rx_cur;
	logic [31:0]                owed_inc, tx_posted_inc, rx_processed_inc;
	logic [31:0]                poll_diff;
	logic                       pa_nz, pb_nz;

	// ring size, saturated into the legal range
	always_comb begin
		log2_sat = {1'b0, cfg.ring_slots_log2};
		if (log2_sat == 5'd0)
			log2_sat = 5'd1;
		if (log2_sat > MAX_LOG2)
			log2_sat = MAX_LOG2;
	end

	assign slots            = 32'd1 << log2_sat;
	assign half             = slots >> 1;
	assign mask             = SLOT_INDEX_BITS'(slots - 32'd1);
	assign tx_cur           = tx_slot_q & mask;
	assign rx_cur           = rx_slot_q & mask;
	assign owed_inc         = owed_q + 32'd1;
	assign tx_posted_inc    = tx_posted_q + 32'd1;
	assign rx_processed_inc = rx_processed_q + 32'd1;
	assign poll_diff        = item.peer_posted_count - rx_processed_q;
	assign pa_nz            = item.peer_credit_slot_a != 32'd0;
	assign pb_nz            = item.peer_credit_slot_b != 32'd0;

	always_comb begin
		send_credit_d  = send_credit_q;
		owed_d         = owed_q;
		ret_sel_d      = ret_sel_q;
		tx_slot_d      = tx_slot_q;
		tx_posted_d    = tx_posted_q;
		rx_slot_d      = rx_slot_q;
		rx_processed_d = rx_processed_q;
		result         = '0;
		slot_index     = '0;

		case (item.kind)
			KIND_OPEN: begin
				tx_slot_d      = '0;
				tx_posted_d    = '0;
				rx_slot_d      = '0;
				rx_processed_d = '0;
				owed_d         = '0;
				send_credit_d  = {19'd0, cfg.initial_send_credits};
				ret_sel_d      = cfg.grant_on_open;
				if (cfg.grant_on_open) begin
					result.credit_write_valid = 1'b1;
					result.credit_write_slot  = 1'b0;
					result.credit_write_value = slots;
				end
			end
			KIND_SEND: begin
				if (item.payload_length > {16'd0, cfg.max_payload}) begin
					result.status = STATUS_TOO_LONG;
				end else if (send_credit_q == 32'd0) begin
					result.status = STATUS_NO_CREDIT;
				end else begin
					slot_index           = tx_cur;
					send_credit_d        = send_credit_q - 32'd1;
					tx_slot_d            = (tx_cur + 1'b1) & mask;
					tx_posted_d          = tx_posted_inc;
					result.counter_value = tx_posted_inc;
				end
			end
			KIND_COMPLETE: begin
				slot_index = rx_cur;
				owed_d     = owed_inc;
				// batch of owed credits reached half a ring: return it
				if (owed_inc >= half) begin
					result.credit_write_valid = 1'b1;
					result.credit_write_slot  = ret_sel_q;
					result.credit_write_value = owed_inc;
					ret_sel_d                 = ~ret_sel_q;
					owed_d                    = '0;
				end
				rx_slot_d            = (rx_cur + 1'b1) & mask;
				rx_processed_d       = rx_processed_inc;
				result.counter_value = rx_processed_inc;
			end
			KIND_RECLAIM: begin
				send_credit_d       = send_credit_q + item.peer_credit_slot_a
				                      + item.peer_credit_slot_b;
				result.clear_slot_a = pa_nz;
				result.clear_slot_b = pb_nz;
			end
			KIND_POLL: begin
				if (item.peer_ready) begin
					if (poll_diff[31]) begin
						// peer counter behind ours: restart both rings
						rx_slot_d      = '0;
						rx_processed_d = '0;
						tx_slot_d      = '0;
						tx_posted_d    = '0;
					end else begin
						result.new_packets = poll_diff[30:0];
					end
				end
			end
			default: ;
		endcase

		result.credits_now = send_credit_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_credit_q  <= '0;
			owed_q         <= '0;
			ret_sel_q      <= 1'b0;
			tx_slot_q      <= '0;
			tx_posted_q    <= '0;
			rx_slot_q      <= '0;
			rx_processed_q <= '0;
		end else if (advance) begin
			send_credit_q  <= send_credit_d;
			owed_q         <= owed_d;
			ret_sel_q      <= ret_sel_d;
			tx_slot_q      <= tx_slot_d;
			tx_posted_q    <= tx_posted_d;
			rx_slot_q      <= rx_slot_d;
			rx_processed_q <= rx_processed_d;
		end
	end

endmodule

@@ design/srcc_out_reg.sv @@
// ---------------------------------------------------------------------------
// srcc_out_reg
// result register driving the result channel
// ---------------------------------------------------------------------------
module srcc_out_reg #(
	parameter int unsigned SLOT_INDEX_BITS = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_s1,
	input  srcc_pkg::result_t          result,
	input  logic [SLOT_INDEX_BITS-1:0] slot_index,
	output logic                       advance,
	srcc_rsp_if.source                 rsp
);
	import srcc_pkg::*;

	logic                       valid_q;
	result_t                    result_s2;
	logic [SLOT_INDEX_BITS-1:0] slot_s2;

	assign advance = valid_s1 & (~valid_q | rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (~valid_q | rsp.ready) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
			slot_s2   <= slot_index;
		end
	end

	assign rsp.valid              = valid_q;
	assign rsp.status             = result_s2.status;
	assign rsp.slot_index         = slot_s2;
	assign rsp.counter_value      = result_s2.counter_value;
	assign rsp.credit_write_valid = result_s2.credit_write_valid;
	assign rsp.credit_write_slot  = result_s2.credit_write_slot;
	assign rsp.credit_write_value = result_s2.credit_write_value;
	assign rsp.clear_slot_a       = result_s2.clear_slot_a;
	assign rsp.clear_slot_b       = result_s2.clear_slot_b;
	assign rsp.new_packets        = result_s2.new_packets;
	assign rsp.credits_now        = result_s2.credits_now;

endmodule

@@ design/shared_ring_credit_controller.sv @@
// ---------------------------------------------------------------------------
// shared_ring_credit_controller
// credit flow control endpoint for a pair of shared-memory packet rings
// ---------------------------------------------------------------------------
//
//  channel  dir  handshake            beat contents
//  -------  ---  -------------------  ------------------------------------------
//  cmd      in   valid/ready          one event: open, send, completion,
//                                     reclaim or poll, with its operands
//  rsp      out  valid/ready          one result per event: status, slot,
//                                     counter, credit return, clears, credits
//  apb      in   psel/penable/pready  configuration registers, word addressed
//
//  each event beat passes through the input register, then through the update
//  logic into the result register; one beat per cycle is sustained while
//  rsp.ready stays high, the single endpoint state update per cycle sets
//  that figure
//  reset (arst_n low) clears the endpoint state and both valid flags and
//  loads the register defaults
//  a stalled result beat holds in the result register while one more event
//  waits in the input register; cmd.ready drops only when both are full
//
module shared_ring_credit_controller #(
	parameter int unsigned SLOT_INDEX_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	srcc_cmd_if.sink                        cmd,
	srcc_rsp_if.source                      rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [srcc_pkg::PADDR_BITS-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import srcc_pkg::*;

	cfg_t                       cfg;
	item_t                      item_s1;
	logic                       valid_s1;
	logic                       advance;
	result_t                    result;
	logic [SLOT_INDEX_BITS-1:0] slot_index;

	// configuration registers; the user must write them only while the block is idle, the block does not enforce it
	srcc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// event beat capture
	srcc_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// state update; commits only when the event moves into the result register
	srcc_engine #(
		.SLOT_INDEX_BITS (SLOT_INDEX_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item       (item_s1),
		.cfg        (cfg),
		.result     (result),
		.slot_index (slot_index)
	);

	// result register and downstream handshake
	srcc_out_reg #(
		.SLOT_INDEX_BITS (SLOT_INDEX_BITS)
	) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.result     (result),
		.slot_index (slot_index),
		.advance    (advance),
		.rsp        (rsp)
	);

endmodule

@@ test/shared_ring_credit_controller_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// shared_ring_credit_controller_test
// drives ring events into the credit controller and checks every result beat
// against an in-bench model of the endpoint; register settings change between
// phases while the block is idle
// ---------------------------------------------------------------------------
module shared_ring_credit_controller_test;
	import srcc_pkg::*;

	localparam int unsigned SLOT_BITS = 12;

	// kind values the block must ignore
	localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

	// hold-off length for the receiver stall test, in cycles
	localparam int HOLD_CYCLES = 60;

	typedef struct packed {
		result_t              r;
		logic [SLOT_BITS-1:0] slot;
	} outcome_t;

	typedef struct {
		item_t    ev;
		bit       typed;
		outcome_t want;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [PADDR_BITS-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	srcc_cmd_if cmd_bus ();
	srcc_rsp_if #(.SLOT_INDEX_BITS(SLOT_BITS)) rsp_bus ();

	shared_ring_credit_controller #(.SLOT_INDEX_BITS(SLOT_BITS)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_bus),
		.rsp     (rsp_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// endpoint model state, a private copy of what the block keeps
	cfg_t                 reg_shadow;
	logic [31:0]          model_credits;
	logic [31:0]          owed_credits;
	logic                 return_sel;
	logic [SLOT_BITS-1:0] tx_index;
	logic [31:0]          tx_count;
	logic [SLOT_BITS-1:0] rx_index;
	logic [31:0]          rx_count;

	outcome_t    awaited_results[$];
	script_row_t script[$];

	int send_idle_pct;
	int recv_idle_pct;
	bit hold_req;
	int events_sent;
	int results_seen;
	int settings_used;
	int mismatches;

	// --- model of one event ------------------------------------------------
	// updates the endpoint copy and returns the result beat it should cause
	function automatic outcome_t apply_event(item_t ev);
		outcome_t             o;
		logic [3:0]           lg;
		logic [31:0]          slots;
		logic [SLOT_BITS-1:0] mask;
		logic [SLOT_BITS-1:0] s;
		logic [31:0]          diff;
		o = '0;
		// ring size saturates to the legal range of the slot index
		lg = reg_shadow.ring_slots_log2;
		if (lg < 4'd1)
			lg = 4'd1;
		if (lg > 4'(SLOT_BITS))
			lg = 4'(SLOT_BITS);
		slots = 32'd1 << lg;
		mask = SLOT_BITS'(slots - 32'd1);
		case (ev.kind)
			KIND_OPEN: begin
				tx_index = '0;
				tx_count = '0;
				rx_index = '0;
				rx_count = '0;
				return_sel = 1'b0;
				model_credits = 32'(reg_shadow.initial_send_credits);
				owed_credits = '0;
				// a full ring of credits goes to return slot 0 at once
				if (reg_shadow.grant_on_open) begin
					o.r.credit_write_valid = 1'b1;
					o.r.credit_write_slot = return_sel;
					o.r.credit_write_value = slots;
					return_sel = ~return_sel;
				end
			end
			KIND_SEND: begin
				// length check wins over the credit check; rejects change nothing
				if (ev.payload_length > 32'(reg_shadow.max_payload))
					o.r.status = STATUS_TOO_LONG;
				else if (model_credits == '0)
					o.r.status = STATUS_NO_CREDIT;
				else begin
					s = tx_index & mask;
					o.slot = s;
					model_credits = model_credits - 32'd1;
					tx_index = (s + 1'b1) & mask;
					tx_count = tx_count + 32'd1;
					o.r.counter_value = tx_count;
				end
			end
			KIND_COMPLETE: begin
				s = rx_index & mask;
				o.slot = s;
				owed_credits = owed_credits + 32'd1;
				// batch owed credits until half a ring, alternate return slots
				if (owed_credits >= (slots >> 1)) begin
					o.r.credit_write_valid = 1'b1;
					o.r.credit_write_slot = return_sel;
					o.r.credit_write_value = owed_credits;
					return_sel = ~return_sel;
					owed_credits = '0;
				end
				rx_index = (s + 1'b1) & mask;
				rx_count = rx_count + 32'd1;
				o.r.counter_value = rx_count;
			end
			KIND_RECLAIM: begin
				if (ev.peer_credit_slot_a != '0) begin
					model_credits = model_credits + ev.peer_credit_slot_a;
					o.r.clear_slot_a = 1'b1;
				end
				if (ev.peer_credit_slot_b != '0) begin
					model_credits = model_credits + ev.peer_credit_slot_b;
					o.r.clear_slot_b = 1'b1;
				end
			end
			KIND_POLL: begin
				if (ev.peer_ready) begin
					diff = ev.peer_posted_count - rx_count;
					// peer counter behind ours: both rings start over
					if (diff[31]) begin
						rx_index = '0;
						rx_count = '0;
						tx_index = '0;
						tx_count = '0;
					end else
						o.r.new_packets = diff[30:0];
				end
			end
			default: begin
			end
		endcase
		o.r.credits_now = model_credits;
		return o;
	endfunction

	// --- event builders -----------------------------------------------------
	function automatic item_t ev_of(logic [2:0] kind, logic [31:0] len, logic [31:0] a,
			logic [31:0] b, logic [31:0] posted, logic ready);
		item_t ev;
		ev.kind = kind;
		ev.payload_length = len;
		ev.peer_credit_slot_a = a;
		ev.peer_credit_slot_b = b;
		ev.peer_posted_count = posted;
		ev.peer_ready = ready;
		return ev;
	endfunction

	function automatic outcome_t typed_res(logic [1:0] status, logic cw_valid,
			logic [31:0] cw_value, logic [31:0] credits);
		outcome_t o;
		o = '0;
		o.r.status = status;
		o.r.credit_write_valid = cw_valid;
		o.r.credit_write_value = cw_value;
		o.r.credits_now = credits;
		return o;
	endfunction

	// mostly well-formed traffic around the current endpoint state, with
	// noise in the fields that the chosen kind ignores
	function automatic item_t random_event();
		item_t ev;
		int    pick;
		int    sub;
		ev = ev_of(KIND_POLL, $urandom, $urandom, $urandom, $urandom, 1'($urandom_range(1)));
		pick = $urandom_range(99);
		sub = $urandom_range(99);
		if (pick < 2)
			ev.kind = KIND_OPEN;
		else if (pick < 38) begin
			ev.kind = KIND_SEND;
			if (sub < 60)
				ev.payload_length = $urandom_range(32'(reg_shadow.max_payload), 0);
			else if (sub < 70)
				ev.payload_length = 32'(reg_shadow.max_payload);
			else if (sub < 80)
				ev.payload_length = 32'(reg_shadow.max_payload) + 32'd1;
		end else if (pick < 63)
			ev.kind = KIND_COMPLETE;
		else if (pick < 75) begin
			ev.kind = KIND_RECLAIM;
			if (sub < 40)
				ev.peer_credit_slot_a = '0;
			else if (sub < 85)
				ev.peer_credit_slot_a = $urandom_range(16, 1);
			sub = $urandom_range(99);
			if (sub < 40)
				ev.peer_credit_slot_b = '0;
			else if (sub < 85)
				ev.peer_credit_slot_b = $urandom_range(16, 1);
		end else if (pick < 97) begin
			ev.kind = KIND_POLL;
			ev.peer_ready = ($urandom_range(99) < 85);
			if (sub < 60)
				ev.peer_posted_count = rx_count + $urandom_range(64);
			else if (sub < 75)
				ev.peer_posted_count = rx_count - $urandom_range(64, 1);
		end else
			ev.kind = 3'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
		return ev;
	endfunction

	// --- event channel driver ----------------------------------------------
	// offers one beat, waits for acceptance, then books the expected result;
	// a typed row books its own expectation while the model still advances
	task automatic send_event(input item_t ev, input bit typed, input outcome_t want);
		outcome_t o;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.kind <= ev.kind;
		cmd_bus.payload_length <= ev.payload_length;
		cmd_bus.peer_credit_slot_a <= ev.peer_credit_slot_a;
		cmd_bus.peer_credit_slot_b <= ev.peer_credit_slot_b;
		cmd_bus.peer_posted_count <= ev.peer_posted_count;
		cmd_bus.peer_ready <= ev.peer_ready;
		@(posedge clk);
		while (!cmd_bus.ready)
			@(posedge clk);
		o = apply_event(ev);
		awaited_results.push_back(typed ? want : o);
		events_sent++;
	endtask

	// --- register port ------------------------------------------------------
	// setup cycle then access cycle; the model copy follows the write
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_RING_SLOTS_LOG2:      reg_shadow.ring_slots_log2 = val[3:0];
			REG_MAX_PAYLOAD:          reg_shadow.max_payload = val[15:0];
			REG_INITIAL_SEND_CREDITS: reg_shadow.initial_send_credits = val[12:0];
			REG_GRANT_ON_OPEN:        reg_shadow.grant_on_open = val[0];
			default: begin
			end
		endcase
	endtask

	task automatic wait_drained();
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// one register setting followed by a stretch of random traffic; the
	// settings are only touched once every booked result has come back
	task automatic run_phase(input logic [3:0] lg, input logic [15:0] maxp,
			input logic [12:0] init, input logic grant, input bit open_first, input int count);
		wait_drained();
		write_reg(REG_RING_SLOTS_LOG2, 32'(lg));
		write_reg(REG_MAX_PAYLOAD, 32'(maxp));
		write_reg(REG_INITIAL_SEND_CREDITS, 32'(init));
		write_reg(REG_GRANT_ON_OPEN, 32'(grant));
		settings_used++;
		// without an open the old indices run on under the new ring size
		if (open_first)
			send_event(ev_of(KIND_OPEN, $urandom, $urandom, $urandom, $urandom, 1'b0),
				1'b0, '0);
		repeat (count)
			send_event(random_event(), 1'b0, '0);
		cmd_bus.valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// --- result channel -----------------------------------------------------
	// ready is set for the next edge; a beat counts at an edge where the
	// ready driven earlier and the block's valid are both high
	initial begin : result_side
		int       hold_left;
		outcome_t want;
		hold_left = 0;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_bus.valid && rsp_bus.ready) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					$error("result beat with no event waiting for it");
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					check_field("status", 32'(want.r.status), 32'(rsp_bus.status));
					check_field("slot_index", 32'(want.slot), 32'(rsp_bus.slot_index));
					check_field("counter_value", want.r.counter_value, rsp_bus.counter_value);
					check_field("credit_write_valid", 32'(want.r.credit_write_valid),
						32'(rsp_bus.credit_write_valid));
					check_field("credit_write_slot", 32'(want.r.credit_write_slot),
						32'(rsp_bus.credit_write_slot));
					check_field("credit_write_value", want.r.credit_write_value,
						rsp_bus.credit_write_value);
					check_field("clear_slot_a", 32'(want.r.clear_slot_a),
						32'(rsp_bus.clear_slot_a));
					check_field("clear_slot_b", 32'(want.r.clear_slot_b),
						32'(rsp_bus.clear_slot_b));
					check_field("new_packets", 32'(want.r.new_packets), 32'(rsp_bus.new_packets));
					check_field("credits_now", want.r.credits_now, rsp_bus.credits_now);
				end
			end
			// a long hold-off lets the block fill and push back on events
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else
				rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// --- main sequence ------------------------------------------------------
	initial begin : stimulus
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cmd_bus.valid <= 1'b0;
		cmd_bus.kind <= KIND_OPEN;
		cmd_bus.payload_length <= '0;
		cmd_bus.peer_credit_slot_a <= '0;
		cmd_bus.peer_credit_slot_b <= '0;
		cmd_bus.peer_posted_count <= '0;
		cmd_bus.peer_ready <= 1'b0;
		hold_req = 1'b0;
		events_sent = 0;
		results_seen = 0;
		settings_used = 1;
		mismatches = 0;
		// sender idles less than the receiver to start with
		send_idle_pct = 34;
		recv_idle_pct = 55;

		// model starts from the reset state of the block
		reg_shadow.ring_slots_log2 = RST_RING_SLOTS_LOG2;
		reg_shadow.max_payload = RST_MAX_PAYLOAD;
		reg_shadow.initial_send_credits = RST_INITIAL_SEND_CREDITS;
		reg_shadow.grant_on_open = RST_GRANT_ON_OPEN;
		model_credits = '0;
		owed_credits = '0;
		return_sel = 1'b0;
		tx_index = '0;
		tx_count = '0;
		rx_index = '0;
		rx_count = '0;

		// directed events under the reset settings: 256-slot ring, 1992 byte
		// limit, no credits on open, full ring granted on open
		script.push_back('{ev_of(KIND_POLL, '1, '1, '1, '1, 1'b0), 1'b1,
			typed_res(STATUS_DONE, 1'b0, '0, '0)});                  // peer not ready
		script.push_back('{ev_of(KIND_SEND, '0, '0, '0, '0, 1'b0), 1'b1,
			typed_res(STATUS_NO_CREDIT, 1'b0, '0, '0)});             // no credit
		script.push_back('{ev_of(KIND_SEND, '1, '0, '0, '0, 1'b0), 1'b1,
			typed_res(STATUS_TOO_LONG, 1'b0, '0, '0)});              // longest length
		script.push_back('{ev_of(KIND_SEND, 32'd1993, '0, '0, '0, 1'b1), 1'b1,
			typed_res(STATUS_TOO_LONG, 1'b0, '0, '0)});              // one past limit
		script.push_back('{ev_of(KIND_UNUSED_FIRST, '1, '1, '1, '1, 1'b1), 1'b1,
			typed_res(STATUS_DONE, 1'b0, '0, '0)});
		script.push_back('{ev_of(KIND_UNUSED_FIRST + 3'd1, '0, '0, '0, '0, 1'b0), 1'b1,
			typed_res(STATUS_DONE, 1'b0, '0, '0)});
		script.push_back('{ev_of(KIND_UNUSED_LAST, '1, '1, '1, '1, 1'b1), 1'b1,
			typed_res(STATUS_DONE, 1'b0, '0, '0)});
		script.push_back('{ev_of(KIND_OPEN, '1, '1, '1, '1, 1'b1), 1'b1,
			typed_res(STATUS_DONE, 1'b1, 32'd256, '0)});             // full ring granted
		script.push_back('{ev_of(KIND_RECLAIM, '1, '0, '0, '1, 1'b1), 1'b1,
			typed_res(STATUS_DONE, 1'b0, '0, '0)});                  // both slots empty
		script.push_back('{ev_of(KIND_RECLAIM, '0, 32'd5, '0, '0, 1'b0), 1'b0, '0});
		script.push_back('{ev_of(KIND_RECLAIM, '0, '0, '1, '0, 1'b0), 1'b0, '0});   // wraps
		script.push_back('{ev_of(KIND_SEND, 32'd1992, '0, '0, '0, 1'b0), 1'b0, '0});
		script.push_back('{ev_of(KIND_SEND, '0, '1, '1, '1, 1'b1), 1'b0, '0});
		script.push_back('{ev_of(KIND_COMPLETE, '1, '1, '1, '1, 1'b1), 1'b0, '0});
		script.push_back('{ev_of(KIND_COMPLETE, '0, '0, '0, '0, 1'b0), 1'b0, '0});
		script.push_back('{ev_of(KIND_POLL, '0, '0, '0, 32'd5, 1'b1), 1'b0, '0});
		script.push_back('{ev_of(KIND_POLL, '0, '0, '0, '0, 1'b1), 1'b0, '0});      // behind
		script.push_back('{ev_of(KIND_POLL, '0, '0, '0, 32'h7fff_ffff, 1'b1), 1'b0, '0});
		script.push_back('{ev_of(KIND_POLL, '0, '0, '0, 32'h8000_0000, 1'b1), 1'b0, '0});
		script.push_back('{ev_of(KIND_RECLAIM, '0, '1, '1, '0, 1'b0), 1'b0, '0});
		script.push_back('{ev_of(KIND_SEND, 32'd100, '0, '0, '0, 1'b0), 1'b0, '0});
		script.push_back('{ev_of(KIND_COMPLETE, '0, '0, '0, '0, 1'b0), 1'b0, '0});
		script.push_back('{ev_of(KIND_OPEN, '0, '0, '0, '0, 1'b0), 1'b0, '0});

		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_event(script[i].ev, script[i].typed, script[i].want);
		cmd_bus.valid <= 1'b0;

		// saturated ring sizes at both ends, then small rings so owed
		// credits come back often
		run_phase(4'd0, 16'd0, 13'd4096, 1'b1, 1'b1, 120);
		wait_drained();
		hold_req = 1'b1;   // receiver stalls long while events keep coming
		run_phase(4'd15, 16'd65535, 13'd0, 1'b0, 1'b1, 120);
		run_phase(4'd3, 16'd1500, 13'd10, 1'b1, 1'b0, 120);

		// receiver now idles less than the sender
		send_idle_pct = 55;
		recv_idle_pct = 34;
		run_phase(4'd1, 16'd64, 13'd1, 1'b0, 1'b1, 120);
		run_phase(4'd12, 16'd65535, 13'd4096, 1'b1, 1'b1, 120);
		run_phase(4'd2, 16'd200, 13'd4095, 1'b1, 1'b0, 120);

		// back to back on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(4'd4, 16'd9000, 13'd100, 1'b0, 1'b1, 120);
		run_phase(4'd5, 16'd1992, 13'd7, 1'b1, 1'b1, 120);
		run_phase(RST_RING_SLOTS_LOG2, RST_MAX_PAYLOAD, RST_INITIAL_SEND_CREDITS,
			RST_GRANT_ON_OPEN, 1'b0, 120);

		// settle: allow a generous margin for strays
		wait_drained();
		repeat (20)
			@(posedge clk);

		$display("%0d events over %0d register settings, %0d result beats compared",
			events_sent, settings_used, results_seen);
		$display("three idle mixes on both channels and one long result stall");
		if (mismatches == 0)
			$display("shared_ring_credit_controller: match");
		else
			$display("shared_ring_credit_controller: mismatch");
		$finish;
	end

	// run limit, far beyond the slowest legal run
	initial begin : watchdog
		#2000000;
		$display("shared_ring_credit_controller: mismatch");
		$finish;
	end

endmodule

@@ filelist.f @@
design/srcc_pkg.sv
design/srcc_cmd_if.sv
design/srcc_rsp_if.sv
design/srcc_cfg_regs.sv
design/srcc_in_reg.sv
design/srcc_engine.sv
design/srcc_out_reg.sv
design/shared_ring_credit_controller.sv
test/shared_ring_credit_controller_test.sv
